[design/pgmsc_pkg.sv]
// ----------------------------------------------------------------------------
// pgmsc_pkg: shared types and constants of the PGM to monochrome scaler
// Holds the result kinds, the character codes of the header parser and the
// width of the header number accumulator.
// ----------------------------------------------------------------------------
package pgmsc_pkg;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_MAGIC = 2'd1,
    KIND_LARGE = 2'd2,
    KIND_SMALL = 2'd3
  } kind_e;

  localparam int unsigned ACC_W = 16;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_5    = 8'h35;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_SP   = 8'h20;

endpackage

[design/pgmsc_div.sv]
// ----------------------------------------------------------------------------
// pgmsc_div: shared restoring divider
// Unsigned division that retires one quotient bit per cycle. A start request
// is taken while idle; a one-cycle done pulse marks a valid quotient.
// ----------------------------------------------------------------------------
module pgmsc_div #(
  parameter int unsigned NumW = 25,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   rem_sh;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q[DenW-1:0], quo_q[NumW-1]};
    fits   = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[NumW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW - 1);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[design/pgm_to_mono_display_scaler.sv]
// ----------------------------------------------------------------------------
// pgm_to_mono_display_scaler: binary PGM to monochrome display scaler
// Parses a P5 header, fits the image to the display and emits one pixel
// write per kept source sample, or one error request per bad file.
// ----------------------------------------------------------------------------
// The file arrives one byte per request, with the result held in an output
// register. A byte that ends a header number without being a digit is
// examined again for the next number. When the size checks pass, the byte
// after maxval starts up to three divisions in turn on one restoring divider
// that produces one quotient bit per cycle.
// The block takes no request while it is busy or while its result waits.
module pgm_to_mono_display_scaler #(
  parameter int unsigned DISPLAY_WIDTH  = 128,
  parameter int unsigned DISPLAY_HEIGHT = 64,
  parameter int unsigned MAX_SOURCE_DIM = 4095
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 first_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pgmsc_pkg::kind_e     result_kind_o,
  output logic [6:0]           pix_x_o,
  output logic [5:0]           pix_y_o,
  output logic                 pix_white_o
);

  import pgmsc_pkg::*;

  localparam int unsigned AccW  = ACC_W;
  localparam int unsigned AccXW = AccW + 4;
  localparam int unsigned SrcW  = $clog2(MAX_SOURCE_DIM + 1);
  localparam int unsigned XW    = $clog2(DISPLAY_WIDTH);
  localparam int unsigned YW    = $clog2(DISPLAY_HEIGHT);
  localparam int unsigned SwW   = $clog2(DISPLAY_WIDTH + 1);
  localparam int unsigned ShW   = $clog2(DISPLAY_HEIGHT + 1);
  localparam int unsigned ScW   = (SwW > ShW) ? SwW : ShW;
  localparam int unsigned NumW  = AccW + ScW;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_MAGIC2,
    PH_W_SKIP,
    PH_W_DIG,
    PH_H_SKIP,
    PH_H_DIG,
    PH_M_SKIP,
    PH_M_DIG,
    PH_PIXELS,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    S_IN,
    S_AGAIN,
    S_HDR,
    S_DIV_SIZE,
    S_DIV_SX,
    S_DIV_SY
  } seq_e;

  seq_e             seq_q, seq_d;
  phase_e           phase_q, phase_d;
  logic             in_comment_q, in_comment_d;
  logic [AccW-1:0]  accum_q, accum_d;
  logic [AccW-1:0]  src_w_q, src_w_d;
  logic [AccW-1:0]  src_h_q, src_h_d;
  logic [AccW-1:0]  max_val_q, max_val_d;
  logic [SwW-1:0]   shown_w_q, shown_w_d;
  logic [ShW-1:0]   shown_h_q, shown_h_d;
  logic [XW-1:0]    off_x_q, off_x_d;
  logic [YW-1:0]    off_y_q, off_y_d;
  logic [SrcW-1:0]  step_x_q, step_x_d;
  logic [SrcW-1:0]  step_y_q, step_y_d;
  logic [SrcW-1:0]  col_q, col_d;
  logic [SrcW-1:0]  row_q, row_d;
  logic [SrcW-1:0]  col_ph_q, col_ph_d;
  logic [SrcW-1:0]  row_ph_q, row_ph_d;
  logic [SrcW-1:0]  xcnt_q, xcnt_d;
  logic [SrcW-1:0]  ycnt_q, ycnt_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             wide_q, wide_d;
  logic             out_valid_q, out_valid_d;
  kind_e            out_kind_q, out_kind_d;
  logic [6:0]       out_x_q, out_x_d;
  logic [5:0]       out_y_q, out_y_d;
  logic             out_white_q, out_white_d;

  logic             accept;
  logic             step_en;
  logic [7:0]       cb;
  logic             last_eff;
  logic             finish;
  logic             again;
  logic             hdr;
  logic             is_space;
  logic             is_digit;
  logic             digit_ph;
  logic             num_ph;
  logic [1:0]       which;
  logic [AccXW-1:0] acc_wide;
  logic [AccW-1:0]  stored;
  logic [NumW-1:0]  w_prod;
  logic [NumW-1:0]  h_prod;
  logic             wide;
  logic             col_last;
  logic             row_last;
  logic             col_wrap;
  logic             row_wrap;
  logic [XW-1:0]    px_sum;
  logic [YW-1:0]    py_sum;
  logic [XW+6:0]    px_ext;
  logic [YW+5:0]    py_ext;
  logic [SwW-1:0]   sw_diff;
  logic [ShW-1:0]   sh_diff;
  logic             div_start;
  logic [NumW-1:0]  div_num;
  logic [AccW-1:0]  div_den;
  logic             div_done;
  logic [NumW-1:0]  div_quot;

  pgmsc_div #(
    .NumW (NumW),
    .DenW (AccW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign in_ready_o = (seq_q == S_IN) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    seq_d        = seq_q;
    phase_d      = phase_q;
    in_comment_d = in_comment_q;
    accum_d      = accum_q;
    src_w_d      = src_w_q;
    src_h_d      = src_h_q;
    max_val_d    = max_val_q;
    shown_w_d    = shown_w_q;
    shown_h_d    = shown_h_q;
    off_x_d      = off_x_q;
    off_y_d      = off_y_q;
    step_x_d     = step_x_q;
    step_y_d     = step_y_q;
    col_d        = col_q;
    row_d        = row_q;
    col_ph_d     = col_ph_q;
    row_ph_d     = row_ph_q;
    xcnt_d       = xcnt_q;
    ycnt_d       = ycnt_q;
    byte_d       = byte_q;
    last_d       = last_q;
    wide_d       = wide_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_white_d  = out_white_q;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    finish       = 1'b0;
    again        = 1'b0;
    hdr          = 1'b0;

    step_en  = (seq_q == S_AGAIN) || (seq_q == S_IN && accept);
    cb       = (seq_q == S_AGAIN) ? byte_q : data_byte_i;
    last_eff = (seq_q == S_IN) ? last_byte_i : last_q;
    is_space = (cb == CH_SP) || (cb inside {[CH_TAB:CH_CR]});
    is_digit = cb inside {[CH_0:CH_9]};
    digit_ph = (phase_q == PH_W_DIG) || (phase_q == PH_H_DIG) || (phase_q == PH_M_DIG);
    num_ph   = digit_ph || (phase_q == PH_W_SKIP) || (phase_q == PH_H_SKIP) ||
               (phase_q == PH_M_SKIP);
    case (phase_q)
      PH_W_SKIP, PH_W_DIG: which = 2'd0;
      PH_H_SKIP, PH_H_DIG: which = 2'd1;
      default:             which = 2'd2;
    endcase
    acc_wide = AccXW'(accum_q) * AccXW'(10) + AccXW'(cb - CH_0);
    stored   = digit_ph ? accum_q : '0;

    w_prod = NumW'(src_w_q) * NumW'(DISPLAY_HEIGHT);
    h_prod = NumW'(src_h_q) * NumW'(DISPLAY_WIDTH);
    wide   = w_prod >= h_prod;

    col_last = col_q == SrcW'(src_w_q - AccW'(1));
    row_last = row_q == SrcW'(src_h_q - AccW'(1));
    col_wrap = col_ph_q == (step_x_q - SrcW'(1));
    row_wrap = row_ph_q == (step_y_q - SrcW'(1));
    px_sum   = off_x_q + xcnt_q[XW-1:0];
    py_sum   = off_y_q + ycnt_q[YW-1:0];
    px_ext   = {7'd0, px_sum};
    py_ext   = {6'd0, py_sum};
    sw_diff  = SwW'(DISPLAY_WIDTH) - shown_w_q;
    sh_diff  = ShW'(DISPLAY_HEIGHT) - shown_h_q;

    case (seq_q)
      S_IN, S_AGAIN: begin
        if (step_en) begin
          if (seq_q == S_IN) begin
            last_d = last_byte_i;
          end
          if (seq_q == S_IN && first_byte_i) begin
            in_comment_d = 1'b0;
            accum_d      = '0;
            src_w_d      = '0;
            src_h_d      = '0;
            max_val_d    = '0;
            col_d        = '0;
            row_d        = '0;
            if (cb == CH_P) begin
              phase_d = PH_MAGIC2;
            end else begin
              phase_d     = PH_DONE;
              out_valid_d = 1'b1;
              out_kind_d  = KIND_MAGIC;
              out_x_d     = '0;
              out_y_d     = '0;
              out_white_d = 1'b0;
            end
          end else if (phase_q == PH_MAGIC2) begin
            if (cb == CH_5) begin
              phase_d = PH_W_SKIP;
            end else begin
              phase_d     = PH_DONE;
              out_valid_d = 1'b1;
              out_kind_d  = KIND_MAGIC;
              out_x_d     = '0;
              out_y_d     = '0;
              out_white_d = 1'b0;
            end
          end else if (num_ph) begin
            if (!digit_ph && in_comment_q) begin
              if (cb == CH_LF) begin
                in_comment_d = 1'b0;
              end
            end else if (!digit_ph && is_space) begin
              in_comment_d = in_comment_q;
            end else if (!digit_ph && cb == CH_HASH) begin
              in_comment_d = 1'b1;
            end else if (is_digit) begin
              accum_d = (acc_wide > AccXW'(ACC_MAX)) ? ACC_MAX : acc_wide[AccW-1:0];
              case (phase_q)
                PH_W_SKIP: phase_d = PH_W_DIG;
                PH_H_SKIP: phase_d = PH_H_DIG;
                PH_M_SKIP: phase_d = PH_M_DIG;
                default:   phase_d = phase_q;
              endcase
            end else begin
              accum_d = '0;
              case (which)
                2'd0: begin
                  src_w_d      = stored;
                  phase_d      = PH_H_SKIP;
                  in_comment_d = 1'b0;
                  again        = 1'b1;
                end
                2'd1: begin
                  src_h_d      = stored;
                  phase_d      = PH_M_SKIP;
                  in_comment_d = 1'b0;
                  again        = 1'b1;
                end
                default: begin
                  max_val_d = stored;
                  phase_d   = PH_DONE;
                  col_d     = '0;
                  row_d     = '0;
                  hdr       = 1'b1;
                end
              endcase
            end
          end else if (phase_q == PH_PIXELS) begin
            if (row_ph_q == '0 && col_ph_q == '0 &&
                xcnt_q < SrcW'(shown_w_q) && ycnt_q < SrcW'(shown_h_q)) begin
              out_valid_d = 1'b1;
              out_kind_d  = KIND_PIXEL;
              out_x_d     = px_ext[6:0];
              out_y_d     = py_ext[5:0];
              out_white_d = AccW'({cb, 1'b0}) >= max_val_q;
            end
            if (col_last) begin
              col_d    = '0;
              col_ph_d = '0;
              xcnt_d   = '0;
              row_d    = row_q + SrcW'(1);
              row_ph_d = row_wrap ? '0 : row_ph_q + SrcW'(1);
              ycnt_d   = row_wrap ? ycnt_q + SrcW'(1) : ycnt_q;
              if (row_last) begin
                phase_d = PH_DONE;
              end
            end else begin
              col_d    = col_q + SrcW'(1);
              col_ph_d = col_wrap ? '0 : col_ph_q + SrcW'(1);
              xcnt_d   = col_wrap ? xcnt_q + SrcW'(1) : xcnt_q;
            end
          end
          if (again) begin
            seq_d  = S_AGAIN;
            byte_d = cb;
          end else if (hdr) begin
            seq_d = S_HDR;
          end else begin
            seq_d  = S_IN;
            finish = 1'b1;
          end
        end
      end
      S_HDR: begin
        out_x_d     = '0;
        out_y_d     = '0;
        out_white_d = 1'b0;
        if (src_w_q > AccW'(MAX_SOURCE_DIM) || src_h_q > AccW'(MAX_SOURCE_DIM)) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_LARGE;
          seq_d       = S_IN;
          finish      = 1'b1;
        end else if (src_w_q == '0 || src_h_q == '0 ||
                     (wide && src_w_q < AccW'(DISPLAY_WIDTH)) ||
                     (!wide && src_h_q < AccW'(DISPLAY_HEIGHT))) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_SMALL;
          seq_d       = S_IN;
          finish      = 1'b1;
        end else begin
          wide_d    = wide;
          div_start = 1'b1;
          div_num   = wide ? h_prod : w_prod;
          div_den   = wide ? src_w_q : src_h_q;
          seq_d     = S_DIV_SIZE;
        end
      end
      S_DIV_SIZE: begin
        if (div_done) begin
          if (div_quot == '0) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_SMALL;
            out_x_d     = '0;
            out_y_d     = '0;
            out_white_d = 1'b0;
            seq_d       = S_IN;
            finish      = 1'b1;
          end else begin
            div_start = 1'b1;
            div_num   = NumW'(src_w_q);
            seq_d     = S_DIV_SX;
            if (wide_q) begin
              shown_w_d = SwW'(DISPLAY_WIDTH);
              shown_h_d = div_quot[ShW-1:0];
              div_den   = AccW'(DISPLAY_WIDTH);
            end else begin
              shown_w_d = div_quot[SwW-1:0];
              shown_h_d = ShW'(DISPLAY_HEIGHT);
              div_den   = div_quot[AccW-1:0];
            end
          end
        end
      end
      S_DIV_SX: begin
        if (div_done) begin
          step_x_d  = div_quot[SrcW-1:0];
          div_start = 1'b1;
          div_num   = NumW'(src_h_q);
          div_den   = AccW'(shown_h_q);
          seq_d     = S_DIV_SY;
        end
      end
      S_DIV_SY: begin
        if (div_done) begin
          step_y_d = div_quot[SrcW-1:0];
          off_x_d  = XW'(sw_diff >> 1);
          off_y_d  = YW'(sh_diff >> 1);
          col_d    = '0;
          row_d    = '0;
          col_ph_d = '0;
          row_ph_d = '0;
          xcnt_d   = '0;
          ycnt_d   = '0;
          phase_d  = PH_PIXELS;
          seq_d    = S_IN;
          finish   = 1'b1;
        end
      end
      default: begin
        seq_d = S_IN;
      end
    endcase

    if (finish && last_eff) begin
      phase_d      = PH_IDLE;
      in_comment_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= S_IN;
      phase_q      <= PH_IDLE;
      in_comment_q <= 1'b0;
      accum_q      <= '0;
      src_w_q      <= '0;
      src_h_q      <= '0;
      max_val_q    <= '0;
      shown_w_q    <= '0;
      shown_h_q    <= '0;
      off_x_q      <= '0;
      off_y_q      <= '0;
      step_x_q     <= '0;
      step_y_q     <= '0;
      col_q        <= '0;
      row_q        <= '0;
      col_ph_q     <= '0;
      row_ph_q     <= '0;
      xcnt_q       <= '0;
      ycnt_q       <= '0;
      byte_q       <= '0;
      last_q       <= 1'b0;
      wide_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_PIXEL;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_white_q  <= 1'b0;
    end else begin
      seq_q        <= seq_d;
      phase_q      <= phase_d;
      in_comment_q <= in_comment_d;
      accum_q      <= accum_d;
      src_w_q      <= src_w_d;
      src_h_q      <= src_h_d;
      max_val_q    <= max_val_d;
      shown_w_q    <= shown_w_d;
      shown_h_q    <= shown_h_d;
      off_x_q      <= off_x_d;
      off_y_q      <= off_y_d;
      step_x_q     <= step_x_d;
      step_y_q     <= step_y_d;
      col_q        <= col_d;
      row_q        <= row_d;
      col_ph_q     <= col_ph_d;
      row_ph_q     <= row_ph_d;
      xcnt_q       <= xcnt_d;
      ycnt_q       <= ycnt_d;
      byte_q       <= byte_d;
      last_q       <= last_d;
      wide_q       <= wide_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_x_q      <= out_x_d;
      out_y_q      <= out_y_d;
      out_white_q  <= out_white_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign pix_x_o       = out_x_q;
  assign pix_y_o       = out_y_q;
  assign pix_white_o   = out_white_q;

endmodule

[tb/sv/pgm_scaler_checker.sv]
// ----------------------------------------------------------------------------
// pgm_scaler_checker: result checker for the PGM to monochrome scaler
// Watches both request channels, runs its own PGM header parser and display
// fit on every accepted byte, and compares each result request field by
// field with the oldest predicted pixel write or error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgm_scaler_checker #(
  parameter int unsigned DISPLAY_WIDTH  = 128,
  parameter int unsigned DISPLAY_HEIGHT = 64,
  parameter int unsigned MAX_SOURCE_DIM = 4095
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       data_byte_i,
  input  logic             first_byte_i,
  input  logic             last_byte_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  pgmsc_pkg::kind_e result_kind_i,
  input  logic [6:0]       pix_x_i,
  input  logic [5:0]       pix_y_i,
  input  logic             pix_white_i,
  output int               error_count_o,
  output int               outstanding_o
);

  import pgmsc_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_MAGIC2     = 4'd1,
    PH_W_SKIP     = 4'd2,
    PH_W_DIGITS   = 4'd3,
    PH_H_SKIP     = 4'd4,
    PH_H_DIGITS   = 4'd5,
    PH_MAX_SKIP   = 4'd6,
    PH_MAX_DIGITS = 4'd7,
    PH_PIXELS     = 4'd8,
    PH_DONE       = 4'd9
  } phase_e;

  typedef struct {
    kind_e      kind;
    logic [6:0] x;
    logic [5:0] y;
    logic       white;
  } pixel_write_t;

  pixel_write_t display_writes_q[$];

  phase_e      phase;
  logic        in_comment;
  logic [15:0] num_acc;
  logic [15:0] src_w;
  logic [15:0] src_h;
  logic [15:0] max_val;
  logic [7:0]  shown_w;
  logic [6:0]  shown_h;
  logic [6:0]  off_x;
  logic [5:0]  off_y;
  logic [15:0] step_x;
  logic [15:0] step_y;
  logic [15:0] src_col;
  logic [15:0] src_row;

  int mismatches;
  int pending;

  assign error_count_o = mismatches;
  assign outstanding_o = pending;

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  task automatic reset_parser();
    phase      = PH_IDLE;
    in_comment = 1'b0;
    num_acc    = '0;
    src_w      = '0;
    src_h      = '0;
    max_val    = '0;
    shown_w    = '0;
    shown_h    = '0;
    off_x      = '0;
    off_y      = '0;
    step_x     = '0;
    step_y     = '0;
    src_col    = '0;
    src_row    = '0;
  endtask

  task automatic parse_pgm_byte(input logic [7:0] b, input logic first, input logic last);
    bit           again;
    bit           hit;
    bit           fits;
    bit           digit_ph;
    kind_e        kind;
    phase_e       p;
    int unsigned  which;
    int unsigned  v;
    int unsigned  dw;
    int unsigned  dh;
    int unsigned  col_x;
    int unsigned  row_y;
    int unsigned  w;
    int unsigned  h;
    pixel_write_t wr;
    hit      = 1'b0;
    again    = 1'b1;
    kind     = KIND_PIXEL;
    wr.x     = '0;
    wr.y     = '0;
    wr.white = 1'b0;
    if (first) begin
      reset_parser();
      if (b == CH_P) begin
        phase = PH_MAGIC2;
      end else begin
        phase = PH_DONE;
        hit   = 1'b1;
        kind  = KIND_MAGIC;
      end
      again = 1'b0;
    end
    while (again) begin
      p     = phase;
      again = 1'b0;
      if (p == PH_MAGIC2) begin
        if (b == CH_5) begin
          phase = PH_W_SKIP;
        end else begin
          phase = PH_DONE;
          hit   = 1'b1;
          kind  = KIND_MAGIC;
        end
      end else if (p >= PH_W_SKIP && p <= PH_MAX_DIGITS) begin
        which    = (int'(p) - int'(PH_W_SKIP)) / 2;
        digit_ph = (int'(p) % 2) == 1;
        if (!digit_ph && in_comment) begin
          if (b == CH_LF) in_comment = 1'b0;
        end else if (!digit_ph && is_blank(b)) begin
        end else if (!digit_ph && b == CH_HASH) begin
          in_comment = 1'b1;
        end else if (is_digit(b)) begin
          v       = int'(num_acc) * 10 + int'(b) - int'(CH_0);
          num_acc = (v > int'(ACC_MAX)) ? ACC_MAX : 16'(v);
          if (!digit_ph) phase = phase_e'(int'(p) + 1);
        end else begin
          v = digit_ph ? int'(num_acc) : 0;
          case (which)
            0: src_w = 16'(v);
            1: src_h = 16'(v);
            default: max_val = 16'(v);
          endcase
          num_acc = '0;
          if (which == 2) begin
            w       = 32'(src_w);
            h       = 32'(src_h);
            src_col = '0;
            src_row = '0;
            phase   = PH_DONE;
            hit     = 1'b1;
            fits    = 1'b0;
            dw      = 0;
            dh      = 0;
            if (w > MAX_SOURCE_DIM || h > MAX_SOURCE_DIM) begin
              kind = KIND_LARGE;
            end else begin
              kind = KIND_SMALL;
              if (w != 0 && h != 0) begin
                if (w * DISPLAY_HEIGHT >= h * DISPLAY_WIDTH) begin
                  fits = (w >= DISPLAY_WIDTH);
                  dw   = DISPLAY_WIDTH;
                  dh   = (h * DISPLAY_WIDTH) / w;
                end else begin
                  fits = (h >= DISPLAY_HEIGHT);
                  dh   = DISPLAY_HEIGHT;
                  dw   = (w * DISPLAY_HEIGHT) / h;
                end
                if (fits && dw != 0 && dh != 0) begin
                  shown_w = 8'(dw);
                  shown_h = 7'(dh);
                  off_x   = 7'((DISPLAY_WIDTH - dw) / 2);
                  off_y   = 6'((DISPLAY_HEIGHT - dh) / 2);
                  step_x  = 16'(w / dw);
                  step_y  = 16'(h / dh);
                  phase   = PH_PIXELS;
                  hit     = 1'b0;
                end
              end
            end
          end else begin
            phase      = phase_e'(int'(PH_W_SKIP) + 2 * (which + 1));
            in_comment = 1'b0;
            again      = 1'b1;
          end
        end
      end else if (p == PH_PIXELS) begin
        if (src_row < src_h && src_col < src_w) begin
          if (src_row % step_y == 0 && src_col % step_x == 0) begin
            col_x = 32'(src_col / step_x);
            row_y = 32'(src_row / step_y);
            if (col_x < shown_w && row_y < shown_h) begin
              hit      = 1'b1;
              kind     = KIND_PIXEL;
              wr.x     = 7'(int'(off_x) + col_x);
              wr.y     = 6'(int'(off_y) + row_y);
              wr.white = (2 * int'(b) >= int'(max_val));
            end
          end
          src_col++;
          if (src_col >= src_w) begin
            src_col = '0;
            src_row++;
          end
        end
        if (src_row >= src_h) phase = PH_DONE;
      end
    end
    if (last) begin
      phase      = PH_IDLE;
      in_comment = 1'b0;
    end
    if (hit) begin
      wr.kind = kind;
      display_writes_q.push_back(wr);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_write_t want;
    if (!rst_ni) begin
      reset_parser();
      display_writes_q.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (display_writes_q.size() == 0) begin
          $display("%0t: expected no result, got kind=%0d x=%0d y=%0d white=%0d",
                   $time, result_kind_i, pix_x_i, pix_y_i, pix_white_i);
          mismatches <= mismatches + 1;
        end else begin
          want = display_writes_q.pop_front();
          if (want.kind !== result_kind_i || want.x !== pix_x_i || want.y !== pix_y_i ||
              want.white !== pix_white_i) begin
            $display({"%0t: expected kind=%0d x=%0d y=%0d white=%0d, ",
                      "got kind=%0d x=%0d y=%0d white=%0d"},
                     $time, want.kind, want.x, want.y, want.white,
                     result_kind_i, pix_x_i, pix_y_i, pix_white_i);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_pgm_byte(data_byte_i, first_byte_i, last_byte_i);
      end
      pending <= display_writes_q.size();
    end
  end

endmodule

[tb/sv/pgm_to_mono_display_scaler_tb.sv]
// ----------------------------------------------------------------------------
// pgm_to_mono_display_scaler_tb: testbench top of the PGM to monochrome scaler
// Streams a few hand-made files and then randomly built ones, mostly well
// formed with random spacing, comments, sizes and samples, with bad magic,
// bad sizes, junk, truncation and restarts mixed in, under random idling on
// both channels. The checker module predicts and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgm_to_mono_display_scaler_tb;
  import pgmsc_pkg::*;

  localparam int unsigned DISPLAY_WIDTH  = 128;
  localparam int unsigned DISPLAY_HEIGHT = 64;
  localparam int unsigned MAX_SOURCE_DIM = 4095;
  localparam int unsigned BYTE_TARGET    = 1250;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam logic [7:0]  CH_VT          = 8'h0b;
  localparam logic [7:0]  CH_FF          = 8'h0c;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] data_byte  = 8'h00;
  logic       first_byte = 1'b0;
  logic       last_byte  = 1'b0;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  kind_e      result_kind;
  logic [6:0] pix_x;
  logic [5:0] pix_y;
  logic       pix_white;

  int          error_count;
  int          outstanding;
  bit          steady;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;
  logic [7:0]  file_q[$];

  pgm_to_mono_display_scaler #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
    .MAX_SOURCE_DIM(MAX_SOURCE_DIM)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .first_byte_i (first_byte),
    .last_byte_i  (last_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .result_kind_o(result_kind),
    .pix_x_o      (pix_x),
    .pix_y_o      (pix_y),
    .pix_white_o  (pix_white)
  );

  pgm_scaler_checker #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
    .MAX_SOURCE_DIM(MAX_SOURCE_DIM)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .data_byte_i  (data_byte),
    .first_byte_i (first_byte),
    .last_byte_i  (last_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .result_kind_i(result_kind),
    .pix_x_i      (pix_x),
    .pix_y_i      (pix_y),
    .pix_white_i  (pix_white),
    .error_count_o(error_count),
    .outstanding_o(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    first_byte <= first;
    last_byte  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_file(input bit with_last);
    for (int i = 0; i < file_q.size(); i++) begin
      send_byte(file_q[i], i == 0, with_last && (i == file_q.size() - 1));
    end
    bytes_sent += file_q.size();
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) file_q.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    file_q.delete();
    add_text(s);
    send_file(1'b1);
  endtask

  task automatic add_blank();
    logic [7:0] c;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 5) != 0) begin
        file_q.push_back(blank_char());
      end else begin
        file_q.push_back(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_LF) c = CH_SP;
          file_q.push_back(c);
        end
        file_q.push_back(CH_LF);
      end
    end
  endtask

  task automatic add_number(input int unsigned v);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) file_q.push_back(CH_0);
    add_text($sformatf("%0d", v));
  endtask

  task automatic build_random_file();
    int unsigned     pick;
    int unsigned     w;
    int unsigned     h;
    int unsigned     maxv;
    int unsigned     cap;
    longint unsigned full;
    longint unsigned n;
    logic [7:0]      c;
    file_q.delete();
    pick = $urandom_range(0, 19);
    w    = 0;
    h    = 0;
    cap  = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(8, 90);
    if (pick == 0) begin
      if ($urandom_range(0, 1) == 1) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_P) c = 8'h00;
        file_q.push_back(c);
      end else begin
        file_q.push_back(CH_P);
        c = 8'($urandom_range(0, 255));
        if (c == CH_5) c = 8'hff;
        file_q.push_back(c);
      end
      repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (pick <= 7) begin
        w = $urandom_range(128, 160);
        h = $urandom_range(1, 3);
      end else if (pick <= 12) begin
        w = $urandom_range(1, 3);
        h = $urandom_range(64, 80);
      end else if (pick == 13) begin
        w = $urandom_range(256, 300);
        h = $urandom_range(2, 3);
      end else if (pick == 14) begin
        w = $urandom_range(2, 4);
        h = $urandom_range(128, 140);
      end else if (pick <= 17) begin
        cap = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
          0: begin
            w = $urandom_range(0, 127);
            h = $urandom_range(0, 3);
          end
          1: begin
            h = $urandom_range(1, 63);
            w = $urandom_range(1, 2 * h - 1);
          end
          2: begin
            w = $urandom_range(4096, 99999);
            h = $urandom_range(1, 64);
          end
          default: begin
            w = $urandom_range(128, 200);
            h = $urandom_range(4096, 70000);
          end
        endcase
      end else begin
        w = $urandom_range(0, 5000);
        h = $urandom_range(0, 5000);
      end
      case ($urandom_range(0, 9))
        0: maxv = 0;
        1, 2, 3, 4, 5: maxv = 255;
        6, 7: maxv = $urandom_range(1, 255);
        8: maxv = $urandom_range(256, 65535);
        default: maxv = 1;
      endcase
      add_text("P5");
      if ($urandom_range(0, 3) != 0) add_blank();
      add_number(w);
      add_blank();
      add_number(h);
      add_blank();
      add_number(maxv);
      if ($urandom_range(0, 7) != 0) begin
        file_q.push_back(blank_char());
      end else begin
        c = 8'($urandom_range(0, 255));
        if (c >= CH_0 && c <= CH_9) c = c ^ 8'h40;
        file_q.push_back(c);
      end
      if ($urandom_range(0, 11) == 0) begin
        file_q.insert($urandom_range(2, file_q.size() - 1), 8'($urandom_range(0, 255)));
      end
      full = 64'(w) * 64'(h);
      n    = (full < 64'(cap)) ? full : 64'(cap);
      if (full <= 64'(cap) && $urandom_range(0, 1) == 1) n += 64'($urandom_range(1, 4));
      repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("pgm_to_mono_display_scaler_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    steady     = 1'b0;
    bytes_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    file_q.delete();
    file_q.push_back(8'h00);
    send_file(1'b1);
    send_text("P65");
    send_text("P599999 1 1 ");
    send_text("P5 x");
    file_q.delete();
    add_text("P5#");
    file_q.push_back(8'hff);
    add_text("\n128\t1 0");
    file_q.push_back(CH_VT);
    file_q.push_back(8'hff);
    file_q.push_back(8'h00);
    file_q.push_back(8'h80);
    send_file(1'b1);

    while (bytes_sent < BYTE_TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      build_random_file();
      send_file($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("pgm_to_mono_display_scaler_tb: PASS");
    end else begin
      $display("pgm_to_mono_display_scaler_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/pgmsc_pkg.sv
design/pgmsc_div.sv
design/pgm_to_mono_display_scaler.sv
tb/sv/pgm_scaler_checker.sv
tb/sv/pgm_to_mono_display_scaler_tb.sv
